// ===== hw/rtl/msfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msfs_pkg;

  // Supervisor states, one-hot
  typedef enum logic [6:0] {
    S_INIT        = 7'b0000001,
    S_IDLE        = 7'b0000010,
    S_WORKING     = 7'b0000100,
    S_TEMP_FAULT  = 7'b0001000,
    S_MOTOR_FAULT = 7'b0010000,
    S_SERVO_FAULT = 7'b0100000,
    S_WAIT_RESET  = 7'b1000000
  } fsm_state_t;

  // State codes as reported on the result stream
  localparam logic [2:0] CODE_INIT        = 3'd0;
  localparam logic [2:0] CODE_IDLE        = 3'd1;
  localparam logic [2:0] CODE_WORKING     = 3'd2;
  localparam logic [2:0] CODE_TEMP_FAULT  = 3'd3;
  localparam logic [2:0] CODE_MOTOR_FAULT = 3'd4;
  localparam logic [2:0] CODE_SERVO_FAULT = 3'd5;
  localparam logic [2:0] CODE_WAIT_RESET  = 3'd6;

  // Request kinds carried in tuser
  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_RESET_REQ   = 2'd1;
  localparam logic [1:0] OP_SERVO_MOVED = 2'd2;

  // Error report codes
  localparam logic [1:0] REPORT_NONE  = 2'd0;
  localparam logic [1:0] REPORT_MOTOR = 2'd1;
  localparam logic [1:0] REPORT_SERVO = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MOTOR_CAL    = 2'd0;
  localparam logic [1:0] REG_MOTOR_ENABLE = 2'd1;
  localparam logic [1:0] REG_SERVO_ENABLE = 2'd2;
  localparam logic [1:0] REG_TICK_PERIOD  = 2'd3;

  // Thresholds and time windows
  localparam logic [15:0] HARD_LIMIT_CA     = 16'd4500;
  localparam logic [7:0]  TEMP_LIMIT_C      = 8'd90;
  localparam logic [15:0] SERVO_LIMIT_MV    = 16'd500;
  localparam logic [1:0]  SERVO_MAX_TRIES   = 2'd3;
  localparam logic [31:0] MOTOR_DEBOUNCE_MS = 32'd2500;
  localparam logic [31:0] SERVO_DEBOUNCE_MS = 32'd1000;
  localparam logic [31:0] TEMP_DEBOUNCE_MS  = 32'd1500;
  localparam logic [31:0] SERVO_BLOCK_MS    = 32'd2000;
  localparam logic [31:0] SERVO_CLEAR_MS    = 32'd20000;
  localparam logic signed [17:0] MOTOR_BASE_CA = 18'sd200;
  // Threshold slope is 10 + (calibration - 50), i.e. calibration - 40
  localparam logic signed [8:0]  MOTOR_CAL_OFFSET = 9'sd40;

  localparam logic [6:0]  CAL_RESET    = 7'd50;
  localparam logic [9:0]  PERIOD_RESET = 10'd200;

  // Map a one-hot state to its reported code
  function automatic logic [2:0] state_code(input fsm_state_t s);
    logic [2:0] c;
    case (s)
      S_INIT:        c = CODE_INIT;
      S_IDLE:        c = CODE_IDLE;
      S_WORKING:     c = CODE_WORKING;
      S_TEMP_FAULT:  c = CODE_TEMP_FAULT;
      S_MOTOR_FAULT: c = CODE_MOTOR_FAULT;
      S_SERVO_FAULT: c = CODE_SERVO_FAULT;
      S_WAIT_RESET:  c = CODE_WAIT_RESET;
      default:       c = CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/motor_servo_fault_supervisor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Motor drive fault supervisor.
// Input stream (s_*): one request per transfer; s_tuser selects a check tick,
// an error reset request or a servo moved event, s_tdata carries the
// measurements and the run / error-accepted flags.
// Output stream (m_*): exactly one result per request: the state after the
// request, the error report code and the servo retry pulse.
// Configuration: cfg_we writes register cfg_index with cfg_data;
// write only while no request is in flight.
// A result is valid the cycle after its request is accepted.
// Throughput: one request per cycle unless the result stream stalls; all
// evaluation for a tick is one pass of compare/add logic plus a 9x8
// threshold multiply between the state registers and the result register.
// Stall: the result register holds while m_tready is low; s_tready is high
// whenever the result register is empty or being drained this cycle.
// Reset (rst, synchronous): state goes to init, timers and flags clear,
// registers return to calibration 50, both checks on, 200 ms per tick.
module motor_servo_fault_supervisor_unit
  import msfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [0] start_system, [16:1] motor_current_ca, [23:17] motor_setting,
  // [39:24] servo_voltage_mv, [47:40] temperature_c, [48] error_accepted
  input  wire logic [55:0] s_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_tuser,
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] fault_state, [4:3] error_report, [5] servo_retry
  output logic [7:0]       m_tdata,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  // Configuration registers
  logic [6:0] motor_calibration;
  logic       motor_checks_enable;
  logic       servo_checks_enable;
  logic [9:0] tick_period_ms;

  // Supervisor state
  fsm_state_t  fsm_state, fsm_state_next;
  logic [31:0] now_ms, now_ms_next;
  logic        motor_pending, motor_pending_next;
  logic [31:0] motor_deadline, motor_deadline_next;
  logic        temp_pending, temp_pending_next;
  logic [31:0] temp_deadline, temp_deadline_next;
  logic        servo_pending, servo_pending_next;
  logic [31:0] servo_deadline, servo_deadline_next;
  logic [31:0] servo_block_until, servo_block_until_next;
  logic [31:0] servo_tries_clear_at, servo_tries_clear_at_next;
  logic [1:0]  servo_tries, servo_tries_next;
  logic        reset_requested, reset_requested_next;

  // Result register
  logic [2:0] res_state;
  logic [1:0] res_report, res_report_next;
  logic       res_retry, res_retry_next;

  // Request fields
  logic [1:0]  operation;
  logic        start_system;
  logic [15:0] motor_current_ca;
  logic [6:0]  motor_setting;
  logic [15:0] servo_voltage_mv;
  logic [7:0]  temperature_c;
  logic        error_accepted;

  logic accept;

  assign operation        = s_tuser;
  assign start_system     = s_tdata[0];
  assign motor_current_ca = s_tdata[16:1];
  assign motor_setting    = s_tdata[23:17];
  assign servo_voltage_mv = s_tdata[39:24];
  assign temperature_c    = s_tdata[47:40];
  assign error_accepted   = s_tdata[48];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {2'b00, res_retry, res_report, res_state};

  // Speed-dependent motor threshold in centiamps
  logic signed [8:0]  cal_off;
  logic signed [16:0] motor_prod;
  logic signed [17:0] motor_limit;
  logic               motor_over;
  logic               hard_over;

  always_comb begin
    cal_off     = $signed({2'b00, motor_calibration}) - MOTOR_CAL_OFFSET;
    motor_prod  = cal_off * $signed({1'b0, motor_setting});
    motor_limit = {motor_prod[16], motor_prod} + MOTOR_BASE_CA;
    motor_over  = $signed({2'b00, motor_current_ca}) > motor_limit;
    hard_over   = motor_current_ca > HARD_LIMIT_CA;
  end

  // Evaluate one request
  always_comb begin
    logic [31:0] now_tick;
    logic        servo_armed;

    now_tick = now_ms + {22'd0, tick_period_ms};

    fsm_state_next            = fsm_state;
    now_ms_next               = now_ms;
    motor_pending_next        = motor_pending;
    motor_deadline_next       = motor_deadline;
    temp_pending_next         = temp_pending;
    temp_deadline_next        = temp_deadline;
    servo_pending_next        = servo_pending;
    servo_deadline_next       = servo_deadline;
    servo_block_until_next    = servo_block_until;
    servo_tries_clear_at_next = servo_tries_clear_at;
    servo_tries_next          = servo_tries;
    reset_requested_next      = reset_requested;
    res_report_next           = REPORT_NONE;
    res_retry_next            = 1'b0;
    servo_armed = (servo_block_until < now_tick) && (servo_voltage_mv > SERVO_LIMIT_MV)
                  && servo_checks_enable;

    case (operation)
      OP_RESET_REQ: begin
        reset_requested_next = 1'b1;
      end
      OP_SERVO_MOVED: begin
        servo_block_until_next    = now_ms + SERVO_BLOCK_MS;
        servo_tries_clear_at_next = now_ms + SERVO_CLEAR_MS;
        servo_tries_next          = 2'd0;
      end
      OP_TICK: begin
        now_ms_next = now_tick;
        case (fsm_state)
          S_INIT: begin
            fsm_state_next = S_IDLE;
          end
          S_IDLE: begin
            motor_pending_next = 1'b0;
            if (start_system) begin
              fsm_state_next = S_WORKING;
            end
          end
          S_WORKING: begin
            fsm_state_next = S_WORKING;
            if (!start_system) begin
              fsm_state_next = S_IDLE;
            end
            if (hard_over) begin
              fsm_state_next = S_MOTOR_FAULT;
            end
            // Debounced motor overcurrent
            if (motor_over && motor_checks_enable) begin
              if (!motor_pending) begin
                motor_pending_next  = 1'b1;
                motor_deadline_next = now_tick + MOTOR_DEBOUNCE_MS;
              end else if (motor_deadline < now_tick) begin
                fsm_state_next = S_MOTOR_FAULT;
              end
            end else begin
              motor_pending_next = 1'b0;
            end
            // Servo overcurrent with retries
            if (servo_armed) begin
              if (!servo_pending) begin
                servo_pending_next  = 1'b1;
                servo_deadline_next = now_tick + SERVO_DEBOUNCE_MS;
              end else if (servo_deadline < now_tick) begin
                if (servo_tries < SERVO_MAX_TRIES) begin
                  servo_block_until_next    = now_tick + SERVO_BLOCK_MS;
                  servo_tries_clear_at_next = now_tick + SERVO_CLEAR_MS;
                  servo_tries_next          = servo_tries + 2'd1;
                  res_retry_next            = 1'b1;
                end else begin
                  fsm_state_next   = S_SERVO_FAULT;
                  servo_tries_next = 2'd0;
                end
              end
            end else begin
              if (servo_tries_clear_at < now_tick) begin
                servo_tries_next = 2'd0;
              end
              servo_pending_next = 1'b0;
            end
            // Debounced overtemperature
            if ((temperature_c > TEMP_LIMIT_C) && motor_checks_enable) begin
              if (!temp_pending) begin
                temp_pending_next  = 1'b1;
                temp_deadline_next = now_tick + TEMP_DEBOUNCE_MS;
              end else if (temp_deadline < now_tick) begin
                fsm_state_next = S_TEMP_FAULT;
              end
            end else begin
              temp_pending_next = 1'b0;
            end
          end
          S_TEMP_FAULT: begin
            fsm_state_next = S_TEMP_FAULT;
          end
          S_MOTOR_FAULT, S_SERVO_FAULT: begin
            res_report_next = (fsm_state == S_MOTOR_FAULT) ? REPORT_MOTOR : REPORT_SERVO;
            if (error_accepted) begin
              fsm_state_next = S_WAIT_RESET;
            end else begin
              reset_requested_next   = 1'b0;
              motor_deadline_next    = 32'd0;
              motor_pending_next     = 1'b0;
              servo_pending_next     = 1'b0;
              servo_block_until_next = now_tick + SERVO_BLOCK_MS;
              servo_tries_next       = 2'd0;
              fsm_state_next         = S_IDLE;
            end
          end
          S_WAIT_RESET: begin
            if (reset_requested) begin
              reset_requested_next   = 1'b0;
              motor_deadline_next    = 32'd0;
              motor_pending_next     = 1'b0;
              servo_pending_next     = 1'b0;
              servo_block_until_next = now_tick + SERVO_BLOCK_MS;
              servo_tries_next       = 2'd0;
              fsm_state_next         = S_IDLE;
            end
          end
          default: begin
            fsm_state_next = S_INIT;
          end
        endcase
      end
      default: begin
        // no operation: hold everything
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_calibration   <= CAL_RESET;
      motor_checks_enable <= 1'b1;
      servo_checks_enable <= 1'b1;
      tick_period_ms      <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOTOR_CAL:    motor_calibration   <= cfg_data[6:0];
        REG_MOTOR_ENABLE: motor_checks_enable <= cfg_data[0];
        REG_SERVO_ENABLE: servo_checks_enable <= cfg_data[0];
        REG_TICK_PERIOD:  tick_period_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state            <= S_INIT;
      now_ms               <= 32'd0;
      motor_pending        <= 1'b0;
      motor_deadline       <= 32'd0;
      temp_pending         <= 1'b0;
      temp_deadline        <= 32'd0;
      servo_pending        <= 1'b0;
      servo_deadline       <= 32'd0;
      servo_block_until    <= 32'd0;
      servo_tries_clear_at <= 32'd0;
      servo_tries          <= 2'd0;
      reset_requested      <= 1'b0;
    end else if (accept) begin
      fsm_state            <= fsm_state_next;
      now_ms               <= now_ms_next;
      motor_pending        <= motor_pending_next;
      motor_deadline       <= motor_deadline_next;
      temp_pending         <= temp_pending_next;
      temp_deadline        <= temp_deadline_next;
      servo_pending        <= servo_pending_next;
      servo_deadline       <= servo_deadline_next;
      servo_block_until    <= servo_block_until_next;
      servo_tries_clear_at <= servo_tries_clear_at_next;
      servo_tries          <= servo_tries_next;
      reset_requested      <= reset_requested_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_state  <= state_code(fsm_state_next);
      res_report <= res_report_next;
      res_retry  <= res_retry_next;
    end
  end

  // A retry pulse never comes with a report or a servo fault
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_retry) |->
      ((res_report == REPORT_NONE) && (res_state != CODE_SERVO_FAULT)))
    else $error("servo retry together with a fault report");

  // A reported error always leaves the fault state
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res_report != REPORT_NONE)) |->
      ((res_state == CODE_IDLE) || (res_state == CODE_WAIT_RESET)))
    else $error("error report with unexpected next state");

  // Temperature fault latches until reset
  assert property (@(posedge clk) disable iff (rst)
    (fsm_state == S_TEMP_FAULT) |=> (fsm_state == S_TEMP_FAULT))
    else $error("temperature fault released");

  // Every accepted request leaves a result behind
  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted request without result");

  // Servo retry count never passes the limit
  assert property (@(posedge clk) disable iff (rst)
    servo_tries <= SERVO_MAX_TRIES)
    else $error("servo retry count overflow");

endmodule

`default_nettype wire
